// ===== hdl/nlw_pkg.sv =====
`timescale 1ns / 1ps

package nlw_pkg;

  // Width of the stored light intervals.
  localparam int CountWidth   = 16;
  localparam int WdWidth      = 5;
  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 16;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_SLOW_PERIOD_LOW  = 3'd0,
    REG_SLOW_PERIOD_HIGH = 3'd1,
    REG_FAST_PERIOD_LOW  = 3'd2,
    REG_FAST_PERIOD_HIGH = 3'd3,
    REG_PULSE_LOW        = 3'd4,
    REG_PULSE_HIGH       = 3'd5,
    REG_TIMEOUT_TICKS    = 3'd6,
    REG_WRAP_LIMIT       = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    REQ_EDGE = 1'b0,
    REQ_TICK = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    STATUS_SEARCHING  = 2'd0,
    STATUS_REGISTERED = 2'd1,
    STATUS_PENDING    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    STEP_ON_OFF_LOW  = 2'd0,
    STEP_ON_OFF_HIGH = 2'd1,
    STEP_KEY_HIGH    = 2'd2,
    STEP_KEY_LOW     = 2'd3
  } step_t;

  localparam logic [CfgDataWidth-1:0] SlowPeriodLowReset  = 16'd780;
  localparam logic [CfgDataWidth-1:0] SlowPeriodHighReset = 16'd810;
  localparam logic [CfgDataWidth-1:0] FastPeriodLowReset  = 16'd2900;
  localparam logic [CfgDataWidth-1:0] FastPeriodHighReset = 16'd3100;
  localparam logic [CfgDataWidth-1:0] PulseLowReset       = 16'd55;
  localparam logic [CfgDataWidth-1:0] PulseHighReset      = 16'd65;
  localparam logic [WdWidth-1:0]      TimeoutTicksReset   = 5'd30;
  localparam logic [WdWidth-1:0]      WrapLimitReset      = 5'd30;

  typedef struct packed {
    logic [CountWidth-1:0] slow_period_low;
    logic [CountWidth-1:0] slow_period_high;
    logic [CountWidth-1:0] fast_period_low;
    logic [CountWidth-1:0] fast_period_high;
    logic [CountWidth-1:0] pulse_low;
    logic [CountWidth-1:0] pulse_high;
    logic [WdWidth-1:0]    timeout_ticks;
    logic [WdWidth-1:0]    wrap_limit;
  } cfg_t;

  typedef struct packed {
    req_type_e   req_type;
    logic [15:0] elapsed_count;
  } req_t;

  typedef struct packed {
    status_t link_status;
    logic    on_off_level;
    logic    power_key_level;
  } result_t;

endpackage

// ===== hdl/nlw_if.sv =====
`timescale 1ns / 1ps

interface nlw_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] elapsed_count;

  modport source (output valid, output req_type, output elapsed_count, input ready);
  modport sink (input valid, input req_type, input elapsed_count, output ready);
endinterface

interface nlw_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] link_status;
  logic       on_off_level;
  logic       power_key_level;

  modport source (output valid, output link_status, output on_off_level,
                  output power_key_level, input ready);
  modport sink (input valid, input link_status, input on_off_level,
                input power_key_level, output ready);
endinterface

// ===== hdl/nlw_engine.sv =====
`timescale 1ns / 1ps

module nlw_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  nlw_pkg::req_t    req,
  input  nlw_pkg::cfg_t    cfg,
  output nlw_pkg::result_t result_next
);

  logic                          capture_phase, capture_phase_next;
  logic [nlw_pkg::CountWidth-1:0] first_interval, first_interval_next;
  logic [nlw_pkg::CountWidth-1:0] second_interval, second_interval_next;
  logic [nlw_pkg::WdWidth-1:0]    watchdog_count, watchdog_count_next;
  nlw_pkg::status_t               status_reg, status_reg_next;
  nlw_pkg::step_t                 sequence_step, sequence_step_next;
  logic                           on_off_pin, on_off_pin_next;
  logic                           power_key_pin, power_key_pin_next;

  logic [nlw_pkg::CountWidth-1:0] first_edge, second_edge;
  logic                           pulse_ok, slow_ok, fast_ok;
  logic [nlw_pkg::WdWidth:0]      wd_sum;
  logic [nlw_pkg::WdWidth-1:0]    wd_tick;

  // Intervals as they stand after this edge is captured.
  assign first_edge  = capture_phase ? first_interval
                                     : req.elapsed_count[nlw_pkg::CountWidth-1:0];
  assign second_edge = capture_phase ? req.elapsed_count[nlw_pkg::CountWidth-1:0]
                                     : second_interval;

  assign pulse_ok = (second_edge >= cfg.pulse_low) && (second_edge <= cfg.pulse_high);
  assign slow_ok  = pulse_ok && (first_edge >= cfg.slow_period_low)
                             && (first_edge <= cfg.slow_period_high);
  assign fast_ok  = pulse_ok && (first_edge >= cfg.fast_period_low)
                             && (first_edge <= cfg.fast_period_high);

  // The extra sum bit catches a count that runs past the 5-bit range.
  assign wd_sum  = {1'b0, watchdog_count}
                 + {{nlw_pkg::WdWidth{1'b0}}, (status_reg == nlw_pkg::STATUS_SEARCHING)};
  assign wd_tick = (wd_sum > {1'b0, cfg.wrap_limit}) ? '0 : wd_sum[nlw_pkg::WdWidth-1:0];

  always_comb begin
    capture_phase_next   = capture_phase;
    first_interval_next  = first_interval;
    second_interval_next = second_interval;
    watchdog_count_next  = watchdog_count;
    status_reg_next      = status_reg;
    sequence_step_next   = sequence_step;
    on_off_pin_next      = on_off_pin;
    power_key_pin_next   = power_key_pin;
    if (fire) begin
      if (req.req_type == nlw_pkg::REQ_EDGE) begin
        capture_phase_next   = ~capture_phase;
        first_interval_next  = first_edge;
        second_interval_next = second_edge;
        priority if (slow_ok) begin
          status_reg_next = nlw_pkg::STATUS_SEARCHING;
        end else if (fast_ok) begin
          status_reg_next     = nlw_pkg::STATUS_REGISTERED;
          watchdog_count_next = '0;
        end else begin
          // Neither pattern matched, so the status stands.
          status_reg_next = status_reg;
        end
        if (watchdog_count_next >= cfg.timeout_ticks) begin
          status_reg_next = nlw_pkg::STATUS_PENDING;
        end
      end else begin
        watchdog_count_next = wd_tick;
        if (status_reg == nlw_pkg::STATUS_PENDING) begin
          unique case (sequence_step)
            nlw_pkg::STEP_ON_OFF_LOW: begin
              on_off_pin_next    = 1'b0;
              sequence_step_next = nlw_pkg::STEP_ON_OFF_HIGH;
            end
            nlw_pkg::STEP_ON_OFF_HIGH: begin
              on_off_pin_next    = 1'b1;
              sequence_step_next = nlw_pkg::STEP_KEY_HIGH;
            end
            nlw_pkg::STEP_KEY_HIGH: begin
              power_key_pin_next = 1'b1;
              sequence_step_next = nlw_pkg::STEP_KEY_LOW;
            end
            nlw_pkg::STEP_KEY_LOW: begin
              power_key_pin_next  = 1'b0;
              sequence_step_next  = nlw_pkg::STEP_ON_OFF_LOW;
              status_reg_next     = nlw_pkg::STATUS_SEARCHING;
              watchdog_count_next = '0;
            end
            default: begin
              sequence_step_next = nlw_pkg::STEP_ON_OFF_LOW;
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    result_next.link_status     = status_reg_next;
    result_next.on_off_level    = on_off_pin_next;
    result_next.power_key_level = power_key_pin_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_phase   <= 1'b0;
      first_interval  <= '0;
      second_interval <= '0;
      watchdog_count  <= '0;
      status_reg      <= nlw_pkg::STATUS_SEARCHING;
      sequence_step   <= nlw_pkg::STEP_ON_OFF_LOW;
      on_off_pin      <= 1'b0;
      power_key_pin   <= 1'b0;
    end else begin
      capture_phase   <= capture_phase_next;
      first_interval  <= first_interval_next;
      second_interval <= second_interval_next;
      watchdog_count  <= watchdog_count_next;
      status_reg      <= status_reg_next;
      sequence_step   <= sequence_step_next;
      on_off_pin      <= on_off_pin_next;
      power_key_pin   <= power_key_pin_next;
    end
  end

endmodule

// ===== hdl/net_light_watchdog_power_cycle.sv =====
`timescale 1ns / 1ps

// Modem network-light watchdog. Each request word is either a light edge,
// carrying the timer count since the previous edge, or a periodic tick; every
// request returns exactly one response word with the link status and the
// levels of the on/off and power-key pins after that request. The block takes
// one word per clock while it is not stalled: a word is registered at the
// input, the state update is made from that register, and the response is
// loaded into an output register, from which it is taken. The input side
// keeps accepting while a response waits, and stalls only when both registers
// are full. The eight configuration registers should be written only while
// no word is in flight.
module net_light_watchdog_power_cycle (
  input  logic                                  clk,
  input  logic                                  rst,
  nlw_req_if.sink                               req,
  nlw_rsp_if.source                             rsp,
  input  logic                                  cfg_we,
  input  logic [nlw_pkg::CfgIdxWidth-1:0]       cfg_index,
  input  logic [nlw_pkg::CfgDataWidth-1:0]      cfg_data
);

  nlw_pkg::cfg_t    cfg;
  nlw_pkg::req_t    in_word;
  logic             in_valid;
  nlw_pkg::result_t out_word;
  nlw_pkg::result_t result_next;
  logic             out_valid;
  logic             out_load;
  logic             fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slow_period_low  <= nlw_pkg::SlowPeriodLowReset;
      cfg.slow_period_high <= nlw_pkg::SlowPeriodHighReset;
      cfg.fast_period_low  <= nlw_pkg::FastPeriodLowReset;
      cfg.fast_period_high <= nlw_pkg::FastPeriodHighReset;
      cfg.pulse_low        <= nlw_pkg::PulseLowReset;
      cfg.pulse_high       <= nlw_pkg::PulseHighReset;
      cfg.timeout_ticks    <= nlw_pkg::TimeoutTicksReset;
      cfg.wrap_limit       <= nlw_pkg::WrapLimitReset;
    end else if (cfg_we) begin
      unique case (nlw_pkg::cfg_reg_e'(cfg_index))
        nlw_pkg::REG_SLOW_PERIOD_LOW:  cfg.slow_period_low  <= cfg_data;
        nlw_pkg::REG_SLOW_PERIOD_HIGH: cfg.slow_period_high <= cfg_data;
        nlw_pkg::REG_FAST_PERIOD_LOW:  cfg.fast_period_low  <= cfg_data;
        nlw_pkg::REG_FAST_PERIOD_HIGH: cfg.fast_period_high <= cfg_data;
        nlw_pkg::REG_PULSE_LOW:        cfg.pulse_low        <= cfg_data;
        nlw_pkg::REG_PULSE_HIGH:       cfg.pulse_high       <= cfg_data;
        nlw_pkg::REG_TIMEOUT_TICKS:
          cfg.timeout_ticks <= cfg_data[nlw_pkg::WdWidth-1:0];
        nlw_pkg::REG_WRAP_LIMIT:
          cfg.wrap_limit <= cfg_data[nlw_pkg::WdWidth-1:0];
        default: ;
      endcase
    end
  end

  // The output register can take a new response when it is empty or being read.
  assign out_load  = !out_valid || rsp.ready;
  assign fire      = in_valid && out_load;
  assign req.ready = !in_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_word.req_type      <= nlw_pkg::req_type_e'(req.req_type);
      in_word.elapsed_count <= req.elapsed_count;
    end
  end

  nlw_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .req         (in_word),
    .cfg         (cfg),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word <= result_next;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.link_status     = out_word.link_status;
  assign rsp.on_off_level    = out_word.on_off_level;
  assign rsp.power_key_level = out_word.power_key_level;

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.link_status != 2'd3))
    else $error("response carries an undefined link status");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!in_valid && !out_valid))
    else $error("pipeline holds a word right after reset");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !out_load) |=> (in_valid && $stable(in_word)))
    else $error("stalled input word was lost or overwritten");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |=> (out_valid && $stable(out_word)))
    else $error("pending response changed before it was taken");

endmodule

// ===== verif/light_watchdog_checker.sv =====
`timescale 1ns / 1ps

module light_watchdog_checker
  import nlw_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  nlw_req_if                      req,
  nlw_rsp_if                      rsp,
  input  logic                    cfg_we,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data,
  output int                      mismatches,
  output int                      words_owed
);

  localparam int MaxReports = 40;

  cfg_t                  settings;
  logic                  second_next;
  logic [CountWidth-1:0] first_iv;
  logic [CountWidth-1:0] second_iv;
  logic [WdWidth-1:0]    watchdog;
  status_t               status;
  step_t                 step;
  logic                  on_off;
  logic                  power_key;
  result_t               owed_q[$];

  function automatic logic in_window(logic [CountWidth-1:0] v, logic [CountWidth-1:0] lo,
                                     logic [CountWidth-1:0] hi);
    return v >= lo && v <= hi;
  endfunction

  // Advances the modem state by one request word and returns the status word it yields.
  function automatic result_t predict_status(req_type_e kind, logic [CountWidth-1:0] count);
    logic [WdWidth:0] wd_next;
    logic             pulse_ok;
    result_t          r;
    if (kind == REQ_EDGE) begin
      if (!second_next) begin
        first_iv = count;
      end else begin
        second_iv = count;
      end
      second_next = !second_next;
      pulse_ok = in_window(second_iv, settings.pulse_low, settings.pulse_high);
      // The searching pattern takes priority when both patterns match.
      if (pulse_ok && in_window(first_iv, settings.slow_period_low, settings.slow_period_high)) begin
        status = STATUS_SEARCHING;
      end else if (pulse_ok &&
                   in_window(first_iv, settings.fast_period_low, settings.fast_period_high)) begin
        status = STATUS_REGISTERED;
        watchdog = '0;
      end
      if (watchdog >= settings.timeout_ticks) begin
        status = STATUS_PENDING;
      end
    end else begin
      wd_next = {1'b0, watchdog};
      if (status == STATUS_SEARCHING) begin
        wd_next = wd_next + 1'b1;
      end
      if (wd_next > {1'b0, settings.wrap_limit} || wd_next > 6'd31) begin
        wd_next = '0;
      end
      watchdog = wd_next[WdWidth-1:0];
      if (status == STATUS_PENDING) begin
        case (step)
          STEP_ON_OFF_LOW: begin
            on_off = 1'b0;
            step = STEP_ON_OFF_HIGH;
          end
          STEP_ON_OFF_HIGH: begin
            on_off = 1'b1;
            step = STEP_KEY_HIGH;
          end
          STEP_KEY_HIGH: begin
            power_key = 1'b1;
            step = STEP_KEY_LOW;
          end
          default: begin
            power_key = 1'b0;
            step = STEP_ON_OFF_LOW;
            status = STATUS_SEARCHING;
            watchdog = '0;
          end
        endcase
      end
    end
    r.link_status = status;
    r.on_off_level = on_off;
    r.power_key_level = power_key;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      settings = '{slow_period_low: SlowPeriodLowReset, slow_period_high: SlowPeriodHighReset,
                   fast_period_low: FastPeriodLowReset, fast_period_high: FastPeriodHighReset,
                   pulse_low: PulseLowReset, pulse_high: PulseHighReset,
                   timeout_ticks: TimeoutTicksReset, wrap_limit: WrapLimitReset};
      second_next = 1'b0;
      first_iv = '0;
      second_iv = '0;
      watchdog = '0;
      status = STATUS_SEARCHING;
      step = STEP_ON_OFF_LOW;
      on_off = 1'b0;
      power_key = 1'b0;
      owed_q.delete();
      mismatches = 0;
      words_owed = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SLOW_PERIOD_LOW:  settings.slow_period_low = cfg_data;
          REG_SLOW_PERIOD_HIGH: settings.slow_period_high = cfg_data;
          REG_FAST_PERIOD_LOW:  settings.fast_period_low = cfg_data;
          REG_FAST_PERIOD_HIGH: settings.fast_period_high = cfg_data;
          REG_PULSE_LOW:        settings.pulse_low = cfg_data;
          REG_PULSE_HIGH:       settings.pulse_high = cfg_data;
          REG_TIMEOUT_TICKS:    settings.timeout_ticks = cfg_data[WdWidth-1:0];
          REG_WRAP_LIMIT:       settings.wrap_limit = cfg_data[WdWidth-1:0];
          default: ;
        endcase
      end
      // Responses are checked before the request of the same edge is queued; a
      // word never returns in the cycle it is taken.
      if (rsp.valid && rsp.ready) begin
        if (owed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("%0t: status word with none expected, got status %0d on_off %0d key %0d",
                     $time, rsp.link_status, rsp.on_off_level, rsp.power_key_level);
          end
        end else begin
          want = owed_q.pop_front();
          if (rsp.link_status !== want.link_status) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $display("%0t: link_status expected %0d, got %0d",
                       $time, want.link_status, rsp.link_status);
            end
          end
          if (rsp.on_off_level !== want.on_off_level) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $display("%0t: on_off_level expected %0d, got %0d",
                       $time, want.on_off_level, rsp.on_off_level);
            end
          end
          if (rsp.power_key_level !== want.power_key_level) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $display("%0t: power_key_level expected %0d, got %0d",
                       $time, want.power_key_level, rsp.power_key_level);
            end
          end
        end
      end
      if (req.valid && req.ready) begin
        owed_q.push_back(predict_status(req_type_e'(req.req_type), req.elapsed_count));
      end
      words_owed = owed_q.size();
    end
  end

endmodule

// ===== verif/net_light_watchdog_power_cycle_test.sv =====
`timescale 1ns / 1ps

module net_light_watchdog_power_cycle_test;
  import nlw_pkg::*;

  localparam int HoldOffCycles = 60;
  localparam int PhaseWords    = 50;
  localparam int RandomPhases  = 10;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we;
  logic [CfgIdxWidth-1:0]  cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;
  int                      mismatches;
  int                      words_owed;
  int                      tx_gap_max;
  int                      rx_stall_max;
  bit                      hold_request;
  cfg_t                    plan;

  nlw_req_if req_ch ();
  nlw_rsp_if rsp_ch ();

  net_light_watchdog_power_cycle i_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  light_watchdog_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .words_owed (words_owed)
  );

  always #1 clk = ~clk;

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input req_type_e kind, input logic [CountWidth-1:0] count);
    int gap;
    gap = $urandom_range(tx_gap_max, 0);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.elapsed_count <= count;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (words_owed != 0);
  endtask

  task automatic put_reg(input cfg_reg_e idx, input logic [CfgDataWidth-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic apply_settings(input cfg_t s);
    put_reg(REG_SLOW_PERIOD_LOW, s.slow_period_low);
    put_reg(REG_SLOW_PERIOD_HIGH, s.slow_period_high);
    put_reg(REG_FAST_PERIOD_LOW, s.fast_period_low);
    put_reg(REG_FAST_PERIOD_HIGH, s.fast_period_high);
    put_reg(REG_PULSE_LOW, s.pulse_low);
    put_reg(REG_PULSE_HIGH, s.pulse_high);
    put_reg(REG_TIMEOUT_TICKS, {{(CfgDataWidth-WdWidth){1'b0}}, s.timeout_ticks});
    put_reg(REG_WRAP_LIMIT, {{(CfgDataWidth-WdWidth){1'b0}}, s.wrap_limit});
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_t default_settings();
    return '{slow_period_low: SlowPeriodLowReset, slow_period_high: SlowPeriodHighReset,
             fast_period_low: FastPeriodLowReset, fast_period_high: FastPeriodHighReset,
             pulse_low: PulseLowReset, pulse_high: PulseHighReset,
             timeout_ticks: TimeoutTicksReset, wrap_limit: WrapLimitReset};
  endfunction

  // Returns {low, high}; now and then the window comes out inverted.
  function automatic logic [2*CountWidth-1:0] draw_window();
    logic [CountWidth-1:0] lo;
    logic [CountWidth-1:0] hi;
    lo = CountWidth'($urandom_range(65000, 0));
    hi = lo + CountWidth'($urandom_range(300, 0));
    if ($urandom_range(7, 0) == 0) begin
      return {hi + 1'b1, lo};
    end
    return {lo, hi};
  endfunction

  function automatic cfg_t draw_settings();
    cfg_t s;
    {s.slow_period_low, s.slow_period_high} = draw_window();
    {s.fast_period_low, s.fast_period_high} = draw_window();
    {s.pulse_low, s.pulse_high} = draw_window();
    // Short timeouts let the watchdog fire often enough to exercise the sequencer.
    s.timeout_ticks = $urandom_range(1, 0) ? WdWidth'($urandom_range(6, 0))
                                           : WdWidth'($urandom_range(31, 0));
    s.wrap_limit = WdWidth'($urandom_range(30, 0));
    return s;
  endfunction

  function automatic logic [CountWidth-1:0] pick_in(logic [CountWidth-1:0] lo,
                                                    logic [CountWidth-1:0] hi);
    return CountWidth'($urandom_range(hi, lo));
  endfunction

  function automatic int gap_ceiling();
    case ($urandom_range(2, 0))
      0:       return 0;
      1:       return 5;
      default: return 17;
    endcase
  endfunction

  // Mostly blink pairs and tick bursts built around the current windows, with
  // boundary values and raw noise mixed in.
  task automatic random_traffic(input int n_words);
    int                    sent;
    int                    burst;
    logic [CountWidth-1:0] bound;
    sent = 0;
    while (sent < n_words) begin
      case ($urandom_range(9, 0))
        0, 1, 2, 3: begin
          if ($urandom_range(1, 0)) begin
            send_word(REQ_EDGE, pick_in(plan.slow_period_low, plan.slow_period_high));
          end else begin
            send_word(REQ_EDGE, pick_in(plan.fast_period_low, plan.fast_period_high));
          end
          send_word(REQ_EDGE, pick_in(plan.pulse_low, plan.pulse_high));
          sent += 2;
        end
        4, 5, 6: begin
          burst = $urandom_range(plan.timeout_ticks + 2, 1);
          repeat (burst) send_word(REQ_TICK, CountWidth'($urandom));
          sent += burst;
        end
        7: begin
          case ($urandom_range(5, 0))
            0:       bound = plan.slow_period_low;
            1:       bound = plan.slow_period_high;
            2:       bound = plan.fast_period_low;
            3:       bound = plan.fast_period_high;
            4:       bound = plan.pulse_low;
            default: bound = plan.pulse_high;
          endcase
          send_word(REQ_EDGE, bound + CountWidth'($urandom_range(2, 0)) - 1'b1);
          sent++;
        end
        default: begin
          send_word(REQ_EDGE, CountWidth'($urandom));
          sent++;
        end
      endcase
    end
  endtask

  initial begin : rx_side
    int stall;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request) begin
        // Long hold-off so that both internal registers fill and the input stalls.
        hold_request = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk);
      end else begin
        stall = $urandom_range(rx_stall_max, 0);
        if (stall > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    #1000000;
    $display("net_light_watchdog_power_cycle_test: done, errors");
    $finish;
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_EDGE;
    req_ch.elapsed_count = '0;
    cfg_we = 1'b0;
    cfg_index = REG_SLOW_PERIOD_LOW;
    cfg_data = '0;
    tx_gap_max = 3;
    rx_stall_max = 3;
    hold_request = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Reset windows: count extremes, a fast blink, slow periods at both bounds, pulses at and past theirs.
    send_word(REQ_EDGE, 16'd0);
    send_word(REQ_EDGE, 16'd65535);
    send_word(REQ_TICK, 16'd0);
    send_word(REQ_EDGE, 16'd3000);
    send_word(REQ_EDGE, 16'd60);
    send_word(REQ_TICK, 16'hFFFF);
    send_word(REQ_EDGE, 16'd780);
    send_word(REQ_EDGE, 16'd55);
    send_word(REQ_EDGE, 16'd810);
    send_word(REQ_EDGE, 16'd66);
    drain();

    // Timeout of one: power cycle, halted by a registered match, then resumed.
    plan = default_settings();
    plan.timeout_ticks = 5'd1;
    apply_settings(plan);
    send_word(REQ_EDGE, 16'd795);
    send_word(REQ_EDGE, 16'd60);
    send_word(REQ_TICK, 16'd0);
    send_word(REQ_EDGE, 16'd795);
    send_word(REQ_TICK, 16'd0);
    send_word(REQ_TICK, 16'd0);
    send_word(REQ_EDGE, 16'd60);
    send_word(REQ_EDGE, 16'd3100);
    send_word(REQ_EDGE, 16'd60);
    send_word(REQ_EDGE, 16'd795);
    send_word(REQ_TICK, 16'd0);
    send_word(REQ_EDGE, 16'd60);
    send_word(REQ_TICK, 16'd0);
    send_word(REQ_TICK, 16'd0);
    drain();

    // Both patterns cover everything, so the searching one must win.
    plan = '{slow_period_low: 16'd0, slow_period_high: 16'd65535,
             fast_period_low: 16'd0, fast_period_high: 16'd65535,
             pulse_low: 16'd0, pulse_high: 16'd65535,
             timeout_ticks: 5'd31, wrap_limit: 5'd0};
    apply_settings(plan);
    send_word(REQ_EDGE, 16'd100);
    send_word(REQ_EDGE, 16'd200);
    send_word(REQ_TICK, 16'd0);
    drain();

    // Inverted windows never match; a zero timeout raises the power cycle on any edge.
    plan = '{slow_period_low: 16'd810, slow_period_high: 16'd780,
             fast_period_low: 16'd3100, fast_period_high: 16'd2900,
             pulse_low: 16'd65, pulse_high: 16'd55,
             timeout_ticks: 5'd0, wrap_limit: 5'd30};
    apply_settings(plan);
    send_word(REQ_EDGE, 16'd795);
    send_word(REQ_EDGE, 16'd60);
    send_word(REQ_TICK, 16'd0);
    drain();

    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0: plan = '{slow_period_low: 16'd0, slow_period_high: 16'd65535,
                    fast_period_low: 16'd0, fast_period_high: 16'd65535,
                    pulse_low: 16'd0, pulse_high: 16'd65535,
                    timeout_ticks: 5'd0, wrap_limit: 5'd0};
        1: plan = '{slow_period_low: 16'd65535, slow_period_high: 16'd65535,
                    fast_period_low: 16'd65535, fast_period_high: 16'd65535,
                    pulse_low: 16'd65535, pulse_high: 16'd65535,
                    timeout_ticks: 5'd31, wrap_limit: 5'd30};
        2: plan = default_settings();
        default: plan = draw_settings();
      endcase
      apply_settings(plan);
      if (p == 3 || p == 7) begin
        tx_gap_max = 0;
        rx_stall_max = gap_ceiling();
        hold_request = 1'b1;
      end else begin
        tx_gap_max = gap_ceiling();
        rx_stall_max = gap_ceiling();
      end
      random_traffic(PhaseWords);
      drain();
    end

    repeat (4) @(negedge clk);
    if (mismatches == 0 && words_owed == 0) begin
      $display("net_light_watchdog_power_cycle_test: done, clean");
    end else begin
      $display("net_light_watchdog_power_cycle_test: done, errors");
    end
    $finish;
  end

endmodule
